// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the CRC stream RTL.
// Bodies compile away when SYNTH is defined; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Check a property on every rising edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a cause is followed in the next cycle by an effect
`define ASSERT_NEXT(lbl, clk, rst_n, cause, effect, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (effect)) \
		else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, cause, effect, msg)

`endif

`endif

// ===== rtl/crs_pkg.sv =====
// Shared constants for the reflected CRC-16 stream core.
// No dependencies; imported by every other RTL file but assert_macros.svh.
`default_nettype none

package crs_pkg;

	localparam int unsigned CRC_W      = 16;
	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned APB_DATA_W = 32;
	localparam int unsigned APB_ADDR_W = 3;

	localparam logic [CRC_W-1:0] CRC_INIT   = 16'hFFFF;
	localparam logic [CRC_W-1:0] CRC_XOROUT = 16'hFFFF;
	localparam logic [CRC_W-1:0] POLY_RESET = 16'hA001;

	// Register index, taken from the word address bit of paddr
	localparam logic REG_POLY = 1'b0;

endpackage

`default_nettype wire

// ===== rtl/crs_if.sv =====
// Valid/ready channel interfaces for byte items and CRC results.
// Depends on crs_pkg for field widths.
`default_nettype none

interface crs_in_if
	import crs_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;
	logic              first_byte;
	logic              last_byte;
	logic              no_data;

	modport source (output valid, data_byte, first_byte, last_byte, no_data, input ready);
	modport sink   (input valid, data_byte, first_byte, last_byte, no_data, output ready);
endinterface

interface crs_out_if
	import crs_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [CRC_W-1:0] crc_value;

	modport source (output valid, crc_value, input ready);
	modport sink   (input valid, crc_value, output ready);
endinterface

`default_nettype wire

// ===== rtl/crs_apb_regs.sv =====
// APB register file of the CRC stream core: the reflected polynomial.
// Depends on crs_pkg.
`default_nettype none

module crs_apb_regs
	import crs_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic      [APB_DATA_W-1:0] prdata,
	output logic                       pready,
	output logic      [CRC_W-1:0]      poly
);

	logic [CRC_W-1:0] poly_q;
	logic             reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[APB_ADDR_W-1] == REG_POLY);

	// Take a write in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_q <= POLY_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			poly_q <= pwdata[CRC_W-1:0];
		end
	end

	// Return the register on reads, zero elsewhere
	always_comb begin
		prdata = '0;
		if (reg_sel) begin
			prdata = {{(APB_DATA_W-CRC_W){1'b0}}, poly_q};
		end
	end

	assign poly = poly_q;

endmodule

`default_nettype wire

// ===== rtl/crs_byte_step.sv =====
// One byte of reflected CRC-16 update: XOR in the byte, then eight
// shift-right steps with conditional polynomial XOR. Depends on crs_pkg.
`default_nettype none

module crs_byte_step
	import crs_pkg::*;
(
	input  wire logic [CRC_W-1:0]  crc_in,
	input  wire logic [BYTE_W-1:0] data_byte,
	input  wire logic [CRC_W-1:0]  poly,
	output logic      [CRC_W-1:0]  crc_out
);

	logic [CRC_W-1:0] acc;
	logic             dropped;

	// Unroll the bit steps into XOR logic
	always_comb begin
		acc = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, data_byte};
		for (int k = 0; k < BYTE_W; k++) begin
			dropped = acc[0];
			acc     = acc >> 1;
			if (dropped) begin
				acc = acc ^ poly;
			end
		end
		crc_out = acc;
	end

endmodule

`default_nettype wire

// ===== rtl/crc16_reflected_stream_core.sv =====
// Reflected CRC-16 stream core: top level with input stage, running value
// and result register. Depends on crs_pkg, crs_if, crs_apb_regs,
// crs_byte_step and assert_macros.svh.
//
// Usage: byte items arrive on the data channel (valid/ready) with first_byte,
// last_byte and no_data marks. first_byte restarts the running value at
// 0xFFFF; no_data items carry no byte; a last_byte item produces one
// transaction on the result channel holding the running value XOR 0xFFFF,
// after which the running value returns to 0xFFFF.
// The input register passes a taken last item on to the result register,
// which offers the result. Throughput: one item per cycle while no last
// item waits for result register room; the byte update is combinational.
// The polynomial is to be written over APB at byte address 0 while idle;
// the block does not enforce this. Reset: the running value goes to
// 0xFFFF, the polynomial to 0xA001 (USB), both stages empty. If the result
// receiver stalls, the result register holds; a following non-last item
// still passes, and a further last item waits in the input register, which
// drops data.ready until it can move.
`default_nettype none

`include "assert_macros.svh"

module crc16_reflected_stream_core
	import crs_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	crs_in_if.sink                     data,
	crs_out_if.source                  result,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic      [APB_DATA_W-1:0] prdata,
	output logic                       pready
);

	logic [CRC_W-1:0]  poly;
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              first_s1;
	logic              last_s1;
	logic              empty_s1;
	logic [CRC_W-1:0]  running_q;
	logic [CRC_W-1:0]  crc_base;
	logic [CRC_W-1:0]  crc_step;
	logic [CRC_W-1:0]  crc_next;
	logic              out_space;
	logic              adv_s1;
	logic              out_valid_q;
	logic [CRC_W-1:0]  crc_q;

	crs_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.poly    (poly)
	);

	// Stage handshake: a last item needs room in the result register
	assign out_space  = !out_valid_q || result.ready;
	assign adv_s1     = valid_s1 && (!last_s1 || out_space);
	assign data.ready = !valid_s1 || adv_s1;

	// Capture an accepted transaction into the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (data.ready) begin
			valid_s1 <= data.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (data.ready && data.valid) begin
			byte_s1  <= data.data_byte;
			first_s1 <= data.first_byte;
			last_s1  <= data.last_byte;
			empty_s1 <= data.no_data;
		end
	end

	// Pick the starting value and absorb the byte
	assign crc_base = first_s1 ? CRC_INIT : running_q;

	crs_byte_step u_step (
		.crc_in    (crc_base),
		.data_byte (byte_s1),
		.poly      (poly),
		.crc_out   (crc_step)
	);

	assign crc_next = empty_s1 ? crc_base : crc_step;

	// Advance the running value; restart it after a last item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= CRC_INIT;
		end else if (adv_s1) begin
			running_q <= last_s1 ? CRC_INIT : crc_next;
		end
	end

	// Result register: load on a last item, hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_space) begin
			out_valid_q <= valid_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			crc_q <= crc_next ^ CRC_XOROUT;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.crc_value = crc_q;

	`ASSERT_NEXT(a_restart_after_last, clk, arst_n, adv_s1 && last_s1, running_q == CRC_INIT, "running value not restarted after last item")
	`ASSERT_NEXT(a_last_waits, clk, arst_n, valid_s1 && last_s1 && !out_space, valid_s1 && last_s1, "stalled last item lost from input register")
	`ASSERT_PROP(a_ready_only_when_free, clk, arst_n, data.ready || valid_s1, "input stalled with empty input register")
	`ASSERT_NEXT(a_no_spurious_result, clk, arst_n, !out_valid_q && !(valid_s1 && last_s1), !out_valid_q, "result raised without a last item")

endmodule

`default_nettype wire
